/* hdl/stable_min_priority_queue_unit_defines.svh */
//------------------------------------------------------------------------------
// stable_min_priority_queue_unit_defines
// assertion macros used by the priority queue rtl
//------------------------------------------------------------------------------
`ifndef STABLE_MIN_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_MIN_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SMPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpq assertion failed");

// next-cycle implication, checked out of reset
`define SMPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smpq assertion failed");

`endif

/* hdl/smpq_pkg.sv */
//------------------------------------------------------------------------------
// smpq_pkg
// types and constants of the stable minimum priority queue
//------------------------------------------------------------------------------
package smpq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int PRI_W     = 16;
    localparam int OCC_W     = 5;
    localparam int STATUS_W  = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRI_W-1:0]          pri;
    } entry_t;

    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        entry_t entry;
    } op_t;

endpackage

/* hdl/smpq_req_if.sv */
//------------------------------------------------------------------------------
// smpq_req_if
// request channel: insert or remove operation
//------------------------------------------------------------------------------
interface smpq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic signed [smpq_pkg::VALUE_W-1:0]  value;
    logic [smpq_pkg::PRI_W-1:0]           priority_req;

    modport source (output valid, output func, output value, output priority_req,
                    input ready);
    modport sink   (input valid, input func, input value, input priority_req,
                    output ready);
endinterface

/* hdl/smpq_rsp_if.sv */
//------------------------------------------------------------------------------
// smpq_rsp_if
// response channel: removed value, status and occupancy
//------------------------------------------------------------------------------
interface smpq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [smpq_pkg::VALUE_W-1:0]  removed_value;
    logic [smpq_pkg::STATUS_W-1:0]        status;
    logic [smpq_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output removed_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input occupancy,
                    output ready);
endinterface

/* hdl/smpq_cell.sv */
//------------------------------------------------------------------------------
// smpq_cell
// one slot of the sorted shift register: keeps, takes the new entry,
// shifts from its left neighbor on insert or from its right on remove
//------------------------------------------------------------------------------
module smpq_cell #(
    parameter int INDEX = 0,
    parameter int DEPTH = smpq_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  smpq_pkg::op_t       ctrl,
    input  logic [CNT_W-1:0]    count,
    input  smpq_pkg::entry_t    left_entry,
    input  logic                left_keep,
    input  smpq_pkg::entry_t    right_entry,
    output smpq_pkg::entry_t    entry,
    output logic                keep
);

    smpq_pkg::entry_t entry_reg;
    smpq_pkg::entry_t entry_next;
    logic             occupied;

    assign occupied = (count > CNT_W'(INDEX));
    // equal priority stays ahead of the new entry
    assign keep     = occupied && (entry_reg.pri <= ctrl.entry.pri);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.rem_en)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.ins_en && !keep)
        begin
            entry_next = left_keep ? ctrl.entry : left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* hdl/stable_min_priority_queue_unit.sv */
//------------------------------------------------------------------------------
// stable_min_priority_queue_unit
// priority queue built as a sorted shift register of DEPTH cells
//------------------------------------------------------------------------------
// req carries func (insert or remove), value and priority_req; rsp returns
// one response per request with removed_value, status and occupancy.
// every cell compares its priority with the incoming one in the same cycle,
// so an insert or a remove needs no extra step: one request per cycle is taken
// while rsp is not stalled, and the response is registered for the next cycle.
// equal priorities leave in arrival order. a remove from an empty queue
// returns 0 with status empty; an insert into a full queue is dropped with
// status full. occupancy is the entry count after the request, low 5 bits.
// reset clears the entry count and the response valid flag; the cells and
// the response data hold no reset value and are never read before written.
// while rsp is stalled with a response pending, req.ready is low; a request
// is still taken in the cycle the pending response is taken.
//------------------------------------------------------------------------------
`include "stable_min_priority_queue_unit_defines.svh"

module stable_min_priority_queue_unit #(
    parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    smpq_req_if.sink    req,
    smpq_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic                                rsp_valid_reg;
    logic signed [smpq_pkg::VALUE_W-1:0] removed_value_reg;
    logic signed [smpq_pkg::VALUE_W-1:0] removed_value_next;
    smpq_pkg::status_t                   status_reg;
    smpq_pkg::status_t                   status_next;
    logic [smpq_pkg::OCC_W-1:0]          occupancy_reg;

    logic              accept;
    logic              full;
    logic              empty;
    logic              rsp_is_empty;
    logic              rsp_is_full;
    smpq_pkg::op_t     ctrl;
    smpq_pkg::entry_t  cell_q [DEPTH];
    logic [DEPTH-1:0]  cell_keep;

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    assign ctrl.ins_en      = accept && (req.func == smpq_pkg::FUNC_INSERT) && !full;
    assign ctrl.rem_en      = accept && (req.func == smpq_pkg::FUNC_REMOVE) && !empty;
    assign ctrl.entry.value = req.value;
    assign ctrl.entry.pri   = req.priority_req;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            smpq_pkg::entry_t left_entry;
            smpq_pkg::entry_t right_entry;
            logic             left_keep;

            if (gi == 0)
            begin : g_head
                assign left_entry = ctrl.entry;
                assign left_keep  = 1'b1;
            end
            else
            begin : g_body
                assign left_entry = cell_q[gi-1];
                assign left_keep  = cell_keep[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_entry = cell_q[gi];
            end
            else
            begin : g_inner
                assign right_entry = cell_q[gi+1];
            end

            smpq_cell #(
                .INDEX (gi),
                .DEPTH (DEPTH)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .left_entry  (left_entry),
                .left_keep   (left_keep),
                .right_entry (right_entry),
                .entry       (cell_q[gi]),
                .keep        (cell_keep[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next         = count_reg;
        removed_value_next = '0;
        status_next        = smpq_pkg::ST_OK;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.rem_en)
        begin
            count_next         = count_reg - 1'b1;
            removed_value_next = cell_q[0].value;
        end
        if (req.func == smpq_pkg::FUNC_INSERT && full)
        begin
            status_next = smpq_pkg::ST_FULL;
        end
        else if (req.func == smpq_pkg::FUNC_REMOVE && empty)
        begin
            status_next = smpq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_value_reg <= removed_value_next;
            status_reg        <= status_next;
            occupancy_reg     <= smpq_pkg::OCC_W'(count_next);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.removed_value = removed_value_reg;
    assign rsp.status        = status_reg;
    assign rsp.occupancy     = occupancy_reg;

    assign rsp_is_empty = rsp.valid && (rsp.status == smpq_pkg::ST_EMPTY);
    assign rsp_is_full  = rsp.valid && (rsp.status == smpq_pkg::ST_FULL);

    `SMPQ_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SMPQ_ASSERT_NEXT(a_insert_grows, ctrl.ins_en, count_reg == CNT_W'($past(count_reg) + 1'b1))
    `SMPQ_ASSERT_NOW(a_empty_zero, rsp_is_empty, rsp.removed_value == '0 && rsp.occupancy == '0)
    `SMPQ_ASSERT_NOW(a_full_occ, rsp_is_full, rsp.occupancy == smpq_pkg::OCC_W'(DEPTH))

endmodule
